FILE: rtl/spst_pkg.sv
package spst_pkg;

    // Field widths of the request and result channels.
    localparam int MODE_W      = 2;
    localparam int PIN_W       = 8;
    localparam int TICKS_W     = 20;
    localparam int SLOT_W      = 6;
    localparam int DELTA_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;

    // Configuration port and register widths.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int FRAME_W    = 24;
    localparam int INIT_W     = 16;
    localparam int GAP_W      = 16;

    // Width of the shared arithmetic unit.
    localparam int ALU_W = 32;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP   = 2'd2;

    // Register reset values.
    localparam logic [FRAME_W-1:0] FRAME_RESET = 24'd2000000;
    localparam logic [INIT_W-1:0]  INIT_RESET  = 16'd1800;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd5000;

    // Closing delta reported when the frame is overrun.
    localparam logic [DELTA_W-1:0] OVERRUN_DELTA = 32'hFFFF_FFFF;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Operation codes of a request.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Shared arithmetic unit operations and flags.
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_flags_t;

endpackage

FILE: rtl/servo_pulse_schedule_table.sv
// Operation: an operation on a table of n channels runs a search for the pin and a shift of
// entries where its mode needs them, then the sum pass, the closing remainder (sum, frame,
// init and gap steps) and the output pass, which waits while the result channel stalls.
// Requests: one operation at a time; every table access goes through the single
// registered read port of the table memory, and all tick and delta arithmetic runs through one adder.
// Reset: synchronous, active low; the table is emptied and the registers take defaults.
module servo_pulse_schedule_table #(
    parameter int MAX_ENTRIES = 45
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Request channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata fields from bit 0: pin[7:0], ticks[27:8], zero fill [31:28].
    input  logic [spst_pkg::IN_TDATA_W-1:0]       s_tdata,
    // s_tuser fields from bit 0: mode[1:0].
    input  logic [spst_pkg::MODE_W-1:0]           s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata fields from bit 0: slot[5:0], out_pin[13:6], delta[45:14],
    // entry_count[51:46], zero fill [55:52].
    output logic [spst_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser fields from bit 0: over_period[0], status[2:1].
    output logic [spst_pkg::OUT_TUSER_W-1:0]      m_tuser,
    output logic                                  m_tlast,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [spst_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [spst_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import spst_pkg::*;

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RAM_W  = PIN_W + TICKS_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_EV,
        S_DEL_RD,
        S_DEL_WR,
        S_UP_RD,
        S_UP_EV,
        S_DN_RD,
        S_DN_EV,
        S_WRITE_NEW,
        S_SCHED,
        S_P1_RD,
        S_P1_EV,
        S_P1_ACC,
        S_CL_SUM,
        S_CL_FRAME,
        S_CL_INIT,
        S_CL_GAP,
        S_P2_RD,
        S_P2_EV,
        S_P2_EM,
        S_CLOSE_EM,
        S_EMPTY_EM
    } state_t;

    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [PIN_W-1:0]      pin_reg, pin_next;
    logic [TICKS_W-1:0]    ticks_reg, ticks_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         k_reg, k_next;
    logic                  first_reg, first_next;
    logic [ALU_W-1:0]      prev_reg, prev_next;
    logic [ALU_W-1:0]      first_d_reg, first_d_next;
    logic [ALU_W-1:0]      acc_reg, acc_next;
    logic                  over_reg, over_next;
    logic [PIN_W-1:0]      em_pin_reg, em_pin_next;
    logic [ALU_W-1:0]      em_delta_reg, em_delta_next;

    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [INIT_W-1:0]     init_reg, init_next;
    logic [GAP_W-1:0]      gap_reg, gap_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [PIN_W-1:0]      m_pin_reg, m_pin_next;
    logic [DELTA_W-1:0]    m_delta_reg, m_delta_next;
    logic [SLOT_W-1:0]     m_count_reg, m_count_next;
    logic                  m_over_reg, m_over_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [RAM_W-1:0]      ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [RAM_W-1:0]      ram_rdata;
    logic [PIN_W-1:0]      r_pin;
    logic [TICKS_W-1:0]    r_ticks;

    alu_op_t               alu_op;
    logic [ALU_W-1:0]      alu_a;
    logic [ALU_W-1:0]      alu_b;
    logic [ALU_W-1:0]      alu_res;
    alu_flags_t            alu_flags;

    logic [CW-1:0]         kp1;
    logic [CW-1:0]         km1;
    logic [CW:0]           kp2;
    logic [ALU_W-1:0]      delta_d;
    logic                  out_free;
    mode_t                 in_mode;

    // Table memory: pin in the upper bits, ticks in the lower bits.
    spst_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The one adder that does every tick, pin and delta compare and every sum.
    spst_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .flags  (alu_flags)
    );

    assign r_pin    = ram_rdata[RAM_W-1:TICKS_W];
    assign r_ticks  = ram_rdata[TICKS_W-1:0];
    assign kp1      = k_reg + 1'b1;
    assign km1      = k_reg - 1'b1;
    assign kp2      = {1'b0, k_reg} + (CW + 1)'(2);
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_mode  = mode_t'(s_tuser);

    // The first delta is half the first pulse; later ones subtract the previous delta.
    assign delta_d = (k_reg == '0) ? ALU_W'(r_ticks >> 1) : alu_res;

    // Operand selection for the shared adder.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_FIND_EV: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_pin);
                alu_b  = ALU_W'(pin_reg);
            end
            S_UP_EV: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_ticks);
                alu_b  = ALU_W'(ticks_reg);
            end
            S_DN_EV: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(ticks_reg);
                alu_b  = ALU_W'(r_ticks);
            end
            S_P1_EV, S_P2_EV: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_ticks);
                alu_b  = prev_reg;
            end
            S_P1_ACC: begin
                alu_op = ALU_ADD;
                alu_a  = acc_reg;
                alu_b  = prev_reg;
            end
            S_CL_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = acc_reg;
                alu_b  = first_d_reg;
            end
            S_CL_FRAME: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(frame_reg);
                alu_b  = acc_reg;
            end
            S_CL_INIT: begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = ALU_W'(init_reg);
            end
            S_CL_GAP: begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = ALU_W'(gap_reg);
            end
            default: begin
            end
        endcase
    end

    // Sequencer: table edit, sum pass, closing remainder and output pass.
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pin_next      = pin_reg;
        ticks_next    = ticks_reg;
        status_next   = status_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        first_d_next  = first_d_reg;
        acc_next      = acc_reg;
        over_next     = over_reg;
        em_pin_next   = em_pin_reg;
        em_delta_next = em_delta_reg;
        frame_next    = frame_reg;
        init_next     = init_reg;
        gap_next      = gap_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_slot_next   = m_slot_reg;
        m_pin_next    = m_pin_reg;
        m_delta_next  = m_delta_reg;
        m_count_next  = m_count_reg;
        m_over_next   = m_over_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        ram_we    = 1'b0;
        ram_waddr = k_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = k_reg[AW-1:0];

        // Register writes.
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FRAME: frame_next = cfg_wdata[FRAME_W-1:0];
                CFG_INIT:  init_next  = cfg_wdata[INIT_W-1:0];
                CFG_GAP:   gap_next   = cfg_wdata[GAP_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = in_mode;
                    pin_next    = s_tdata[PIN_W-1:0];
                    ticks_next  = s_tdata[PIN_W+TICKS_W-1:PIN_W];
                    status_next = STATUS_OK;
                    k_next      = '0;
                    first_next  = 1'b1;
                    unique case (in_mode) inside
                        MODE_INSERT: begin
                            if (n_reg == CW'(MAX_ENTRIES)) begin
                                status_next = STATUS_FULL;
                                state_next  = S_SCHED;
                            end else begin
                                k_next     = n_reg;
                                state_next = (n_reg == '0) ? S_WRITE_NEW : S_DN_RD;
                            end
                        end
                        MODE_DELETE, MODE_UPDATE: begin
                            if (n_reg == '0) begin
                                status_next = STATUS_NOT_FOUND;
                                state_next  = S_SCHED;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        default: begin
                            state_next = S_SCHED;
                        end
                    endcase
                end
            end

            // Linear search for the first entry holding the pin.
            S_FIND_RD: begin
                state_next = S_FIND_EV;
            end
            S_FIND_EV: begin
                if (alu_flags.eq) begin
                    if (mode_reg == MODE_DELETE) begin
                        if (kp1 < n_reg) begin
                            state_next = S_DEL_RD;
                        end else begin
                            n_next     = n_reg - 1'b1;
                            state_next = S_SCHED;
                        end
                    end else if (kp1 < n_reg) begin
                        state_next = S_UP_RD;
                    end else begin
                        state_next = (k_reg != '0) ? S_DN_RD : S_WRITE_NEW;
                    end
                end else if (kp1 == n_reg) begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = S_SCHED;
                end else begin
                    k_next     = kp1;
                    state_next = S_FIND_RD;
                end
            end

            // Delete closes the gap one entry at a time.
            S_DEL_RD: begin
                ram_raddr  = kp1[AW-1:0];
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                ram_we = 1'b1;
                k_next = kp1;
                if (kp2 < {1'b0, n_reg}) begin
                    state_next = S_DEL_RD;
                end else begin
                    n_next     = n_reg - 1'b1;
                    state_next = S_SCHED;
                end
            end

            // Update toward larger ticks; the first compare also picks the direction.
            S_UP_RD: begin
                ram_raddr  = kp1[AW-1:0];
                state_next = S_UP_EV;
            end
            S_UP_EV: begin
                first_next = 1'b0;
                if (alu_flags.lt) begin
                    ram_we = 1'b1;
                    k_next = kp1;
                    state_next = (kp2 < {1'b0, n_reg}) ? S_UP_RD : S_WRITE_NEW;
                end else if (first_reg && !alu_flags.eq) begin
                    state_next = (k_reg != '0) ? S_DN_RD : S_WRITE_NEW;
                end else begin
                    state_next = S_WRITE_NEW;
                end
            end

            // Insert, and update toward smaller ticks, shift larger entries up.
            S_DN_RD: begin
                ram_raddr  = km1[AW-1:0];
                state_next = S_DN_EV;
            end
            S_DN_EV: begin
                if (alu_flags.lt) begin
                    ram_we = 1'b1;
                    k_next = km1;
                    state_next = (km1 != '0) ? S_DN_RD : S_WRITE_NEW;
                end else begin
                    state_next = S_WRITE_NEW;
                end
            end

            S_WRITE_NEW: begin
                ram_we    = 1'b1;
                ram_wdata = {pin_reg, ticks_reg};
                if (mode_reg == MODE_INSERT) begin
                    n_next = n_reg + 1'b1;
                end
                state_next = S_SCHED;
            end

            S_SCHED: begin
                k_next     = '0;
                prev_next  = '0;
                acc_next   = '0;
                state_next = (n_reg == '0) ? S_EMPTY_EM : S_P1_RD;
            end

            // First pass: sum of all deltas.
            S_P1_RD: begin
                state_next = S_P1_EV;
            end
            S_P1_EV: begin
                prev_next = delta_d;
                if (k_reg == '0) begin
                    first_d_next = delta_d;
                end
                state_next = S_P1_ACC;
            end
            S_P1_ACC: begin
                acc_next   = alu_res;
                k_next     = kp1;
                state_next = (kp1 == n_reg) ? S_CL_SUM : S_P1_RD;
            end

            // Closing remainder: frame - (sum + first) - init, checked against min gap.
            S_CL_SUM: begin
                acc_next   = alu_res;
                state_next = S_CL_FRAME;
            end
            S_CL_FRAME: begin
                acc_next   = alu_res;
                state_next = S_CL_INIT;
            end
            S_CL_INIT: begin
                acc_next   = alu_res;
                state_next = S_CL_GAP;
            end
            S_CL_GAP: begin
                over_next  = alu_flags.lt;
                k_next     = '0;
                prev_next  = '0;
                state_next = S_P2_RD;
            end

            // Second pass: recompute each delta and send it.
            S_P2_RD: begin
                state_next = S_P2_EV;
            end
            S_P2_EV: begin
                em_pin_next   = r_pin;
                em_delta_next = delta_d;
                state_next    = S_P2_EM;
            end
            S_P2_EM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_slot_next   = SLOT_W'(k_reg);
                    m_pin_next    = em_pin_reg;
                    m_delta_next  = em_delta_reg;
                    m_count_next  = SLOT_W'(n_reg);
                    m_over_next   = over_reg;
                    m_status_next = status_reg;
                    m_last_next   = 1'b0;
                    prev_next     = em_delta_reg;
                    k_next        = kp1;
                    state_next    = (kp1 == n_reg) ? S_CLOSE_EM : S_P2_RD;
                end
            end
            S_CLOSE_EM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_slot_next   = SLOT_W'(n_reg);
                    m_pin_next    = em_pin_reg;
                    m_delta_next  = over_reg ? OVERRUN_DELTA : acc_reg;
                    m_count_next  = SLOT_W'(n_reg);
                    m_over_next   = over_reg;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // Empty table: a single closing result, all fields zero but the status.
            S_EMPTY_EM: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_slot_next   = '0;
                    m_pin_next    = '0;
                    m_delta_next  = '0;
                    m_count_next  = '0;
                    m_over_next   = 1'b0;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            frame_reg    <= FRAME_RESET;
            init_reg     <= INIT_RESET;
            gap_reg      <= GAP_RESET;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            m_tvalid_reg <= m_tvalid_next;
            frame_reg    <= frame_next;
            init_reg     <= init_next;
            gap_reg      <= gap_next;
        end
        mode_reg     <= mode_next;
        pin_reg      <= pin_next;
        ticks_reg    <= ticks_next;
        status_reg   <= status_next;
        k_reg        <= k_next;
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        first_d_reg  <= first_d_next;
        acc_reg      <= acc_next;
        over_reg     <= over_next;
        em_pin_reg   <= em_pin_next;
        em_delta_reg <= em_delta_next;
        m_slot_reg   <= m_slot_next;
        m_pin_reg    <= m_pin_next;
        m_delta_reg  <= m_delta_next;
        m_count_reg  <= m_count_next;
        m_over_reg   <= m_over_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2 * SLOT_W - PIN_W - DELTA_W){1'b0}},
                       m_count_reg, m_delta_reg, m_pin_reg, m_slot_reg};
    assign m_tuser  = {m_status_reg, m_over_reg};
    assign m_tlast  = m_last_reg;

    // The channel count never exceeds the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CW'(MAX_ENTRIES))
        else $error("channel count beyond table depth");

    // The output pass only reads slots inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_P2_EV) |-> (k_reg < n_reg))
        else $error("output pass read beyond table");

    // The closing result sits at the slot equal to the channel count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_slot_reg == m_count_reg))
        else $error("closing slot differs from channel count");

    // An overrun close carries the overrun marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_over_reg) |-> (m_delta_reg == OVERRUN_DELTA))
        else $error("overrun close without marker delta");

    // An accepted request always starts the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

FILE: rtl/spst_ram.sv
module spst_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 45
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/spst_alu.sv
module spst_alu (
    input  spst_pkg::alu_op_t            op,
    input  logic [spst_pkg::ALU_W-1:0]   a,
    input  logic [spst_pkg::ALU_W-1:0]   b,
    output logic [spst_pkg::ALU_W-1:0]   result,
    output spst_pkg::alu_flags_t         flags
);

    import spst_pkg::*;

    logic [ALU_W:0] sum_ext;

    // Signed add or subtract with one guard bit; on a subtract the guard bit
    // is the signed less-than flag.
    always_comb begin
        if (op == ALU_SUB) begin
            sum_ext = {a[ALU_W-1], a} - {b[ALU_W-1], b};
        end else begin
            sum_ext = {a[ALU_W-1], a} + {b[ALU_W-1], b};
        end
    end

    assign result   = sum_ext[ALU_W-1:0];
    assign flags.lt = sum_ext[ALU_W];
    assign flags.eq = (sum_ext[ALU_W-1:0] == '0);

endmodule
